// ----- sv/rmth_pkg.sv -----
// Shared types and constants for the two-heap running median block.
`default_nettype none
package rmth_pkg;

    // Heap sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PUSH_R = 9'b000000010,
        ST_PUSH_C = 9'b000000100,
        ST_DOWN_R = 9'b000001000,
        ST_DOWN_C = 9'b000010000,
        ST_LAST_R = 9'b000100000,
        ST_LAST_C = 9'b001000000,
        ST_NEXT   = 9'b010000000,
        ST_OUT    = 9'b100000000
    } seq_state_t;

    // Heap operation queued for the sequencer.
    typedef enum logic [2:0] {
        OP_NONE    = 3'b001,
        OP_PUSH    = 3'b010,
        OP_REPLACE = 3'b100
    } heap_op_t;

    // Which heap an operation targets.
    localparam logic SIDE_LOWER = 1'b0;
    localparam logic SIDE_UPPER = 1'b1;

    // Step of the per-sample sequence.
    localparam logic [1:0] PH_INSERT = 2'd0;
    localparam logic [1:0] PH_IDLE   = 2'd1;
    localparam logic [1:0] PH_REBAL  = 2'd2;
    localparam logic [1:0] PH_LAST   = 2'd3;

endpackage
`default_nettype wire

// ----- sv/running_median_two_heaps.sv -----
// Top level of the two-heap running median: heap memories and sift sequencer.
// A dropped sample goes straight to its result beat; otherwise each heap operation sifts one
// level per heap RAM access, and a rebalance adds a pop that first reads the last entry of the
// popped heap. Samples are taken one at a time: the next is not accepted until the result
// beat of the last has been taken. Reset (rst_n low, asynchronous) empties both heaps;
// RAMs keep data.
`default_nettype none
module running_median_two_heaps #(
    parameter int HALF_CAPACITY = 512,
    parameter int VALUE_WIDTH   = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [31:0]         sample,
    input  wire logic                       start_new,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [VALUE_WIDTH:0]     twice_median,
    output logic                            overflow
);
    localparam int AW = (HALF_CAPACITY > 1) ? $clog2(HALF_CAPACITY) : 1;
    localparam int CW = $clog2(HALF_CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;
    localparam logic [CW-1:0] CAP = CW'(HALF_CAPACITY);

    typedef logic signed [VW-1:0] val_t;

    // Heap storage, one RAM per half.
    val_t lo_mem [HALF_CAPACITY];
    val_t up_mem [HALF_CAPACITY];

    rmth_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0] lcnt_reg, lcnt_next, ucnt_reg, ucnt_next;
    val_t ltop_reg, ltop_next, utop_reg, utop_next;
    val_t s_reg, s_next;          // value being placed
    val_t mv_reg, mv_next;        // value moved for the follow-up operation
    logic side_reg, side_next;
    rmth_pkg::heap_op_t op_reg, op_next, op2_reg, op2_next;
    logic side2_reg, side2_next;
    logic [1:0] phase_reg, phase_next;   // insert, idle, rebalance or last-entry read
    logic [CW-1:0] pos_reg, pos_next;    // hole index
    logic [CW-1:0] hc_reg, hc_next;      // heap count during sift
    val_t ra_reg, rb_reg;                // registered read data
    logic [AW-1:0] rda, rdb;
    logic          rd_side;
    logic          we;
    logic          we_side;
    logic [AW-1:0] wa;
    val_t          wd;
    logic          ov_reg, ov_next;
    logic          ovl_reg, ovl_next;
    logic signed [VW:0] tm_reg, tm_next;

    // Synchronous RAMs: one write, two reads per cycle.
    always_ff @(posedge clk)
    begin
        if (we && we_side == rmth_pkg::SIDE_LOWER)
        begin
            lo_mem[wa] <= wd;
        end
        if (we && we_side == rmth_pkg::SIDE_UPPER)
        begin
            up_mem[wa] <= wd;
        end
        if (rd_side == rmth_pkg::SIDE_LOWER)
        begin
            ra_reg <= lo_mem[rda];
            rb_reg <= lo_mem[rdb];
        end
        else
        begin
            ra_reg <= up_mem[rda];
            rb_reg <= up_mem[rdb];
        end
    end

    logic is_max;
    logic [CW:0] lch, rch;
    logic [CW-1:0] par;
    val_t cv;
    logic [CW-1:0] ci;
    logic two_ch;

    assign is_max = (side_reg == rmth_pkg::SIDE_LOWER);
    assign par    = (pos_reg - CW'(1)) >> 1;
    assign lch    = {pos_reg, 1'b1};
    assign rch    = lch + (CW+1)'(1);
    assign two_ch = (rch < {1'b0, hc_reg});
    // Pick the child that leads.
    always_comb
    begin
        cv = ra_reg;
        ci = lch[CW-1:0];
        if (two_ch && (is_max ? (rb_reg > ra_reg) : (rb_reg < ra_reg)))
        begin
            cv = rb_reg;
            ci = rch[CW-1:0];
        end
    end

    // Hold the input while a sample is in work or its result waits.
    assign in_stall = (state_reg != rmth_pkg::ST_IDLE) || out_valid;

    logic [CW:0] tot;
    logic [VW+31:0] smp_wide;
    val_t smp;
    assign smp_wide = {{VW{1'b0}}, sample};
    assign smp      = smp_wide[VW-1:0];

    always_comb
    begin
        state_next = state_reg;
        lcnt_next = lcnt_reg; ucnt_next = ucnt_reg;
        ltop_next = ltop_reg; utop_next = utop_reg;
        s_next = s_reg; mv_next = mv_reg; side_next = side_reg;
        op_next = op_reg; op2_next = op2_reg; side2_next = side2_reg;
        phase_next = phase_reg; pos_next = pos_reg; hc_next = hc_reg;
        ov_next = ov_reg; ovl_next = ovl_reg; tm_next = tm_reg;
        rda = '0; rdb = '0; rd_side = side_reg;
        we = 1'b0; we_side = side_reg; wa = '0; wd = s_reg;
        tot = '0;
        case (state_reg)
            rmth_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    lcnt_next = start_new ? '0 : lcnt_reg;
                    ucnt_next = start_new ? '0 : ucnt_reg;
                    tot = {1'b0, lcnt_next} + {1'b0, ucnt_next};
                    s_next = smp;
                    ov_next = 1'b0;
                    op2_next = rmth_pkg::OP_NONE;
                    phase_next = rmth_pkg::PH_IDLE;
                    if (tot >= {CAP, 1'b0})
                    begin
                        ov_next = 1'b1;
                        state_next = rmth_pkg::ST_OUT;
                    end
                    else if (lcnt_next != '0 && smp > ltop_reg)
                    begin
                        side_next = rmth_pkg::SIDE_UPPER;
                        op_next = rmth_pkg::OP_PUSH;
                        state_next = rmth_pkg::ST_NEXT;
                    end
                    else if (lcnt_next >= CAP)
                    begin
                        // Lower top moves up, sample replaces it.
                        side_next = rmth_pkg::SIDE_UPPER;
                        op_next = rmth_pkg::OP_PUSH;
                        s_next = ltop_reg;
                        mv_next = smp;
                        op2_next = rmth_pkg::OP_REPLACE;
                        side2_next = rmth_pkg::SIDE_LOWER;
                        state_next = rmth_pkg::ST_NEXT;
                    end
                    else
                    begin
                        side_next = rmth_pkg::SIDE_LOWER;
                        op_next = rmth_pkg::OP_PUSH;
                        state_next = rmth_pkg::ST_NEXT;
                    end
                    op_next = (tot >= {CAP, 1'b0}) ? rmth_pkg::OP_NONE : op_next;
                    // Start the queued operation next cycle via ST_NEXT.
                    if (state_next == rmth_pkg::ST_NEXT)
                    begin
                        phase_next = rmth_pkg::PH_INSERT;
                    end
                end
            end
            // Launch operation op_reg on side_reg.
            rmth_pkg::ST_NEXT:
            begin
                case (op_reg)
                    rmth_pkg::OP_PUSH:
                    begin
                        pos_next = is_max ? lcnt_reg : ucnt_reg;
                        if (is_max) lcnt_next = lcnt_reg + CW'(1);
                        else ucnt_next = ucnt_reg + CW'(1);
                        state_next = rmth_pkg::ST_PUSH_R;
                    end
                    rmth_pkg::OP_REPLACE:
                    begin
                        pos_next = '0;
                        hc_next = is_max ? lcnt_reg : ucnt_reg;
                        state_next = rmth_pkg::ST_DOWN_R;
                    end
                    default:
                    begin
                        if (op2_reg != rmth_pkg::OP_NONE)
                        begin
                            // Nothing to sift: go straight to the queued push.
                            op_next = op2_reg; side_next = side2_reg; s_next = mv_reg;
                            op2_next = rmth_pkg::OP_NONE;
                            state_next = rmth_pkg::ST_NEXT;
                        end
                        else
                        begin
                            state_next = rmth_pkg::ST_OUT;
                        end
                    end
                endcase
            end
            // Sift up: read parent.
            rmth_pkg::ST_PUSH_R:
            begin
                rda = par[AW-1:0];
                if (pos_reg == '0)
                begin
                    we = 1'b1; wa = '0; wd = s_reg;
                    if (is_max) ltop_next = s_reg; else utop_next = s_reg;
                    state_next = rmth_pkg::ST_LAST_C;
                end
                else
                begin
                    state_next = rmth_pkg::ST_PUSH_C;
                end
            end
            rmth_pkg::ST_PUSH_C:
            begin
                if (is_max ? (s_reg > ra_reg) : (s_reg < ra_reg))
                begin
                    we = 1'b1; wa = pos_reg[AW-1:0]; wd = ra_reg;
                    pos_next = par;
                    state_next = rmth_pkg::ST_PUSH_R;
                end
                else
                begin
                    we = 1'b1; wa = pos_reg[AW-1:0]; wd = s_reg;
                    state_next = rmth_pkg::ST_LAST_C;
                end
            end
            // Sift down: read both children.
            rmth_pkg::ST_DOWN_R:
            begin
                rda = lch[AW-1:0];
                rdb = two_ch ? rch[AW-1:0] : lch[AW-1:0];
                if (lch >= {1'b0, hc_reg})
                begin
                    we = 1'b1; wa = pos_reg[AW-1:0]; wd = s_reg;
                    if (pos_reg == '0)
                    begin
                        if (is_max) ltop_next = s_reg; else utop_next = s_reg;
                    end
                    state_next = rmth_pkg::ST_LAST_C;
                end
                else
                begin
                    state_next = rmth_pkg::ST_DOWN_C;
                end
            end
            rmth_pkg::ST_DOWN_C:
            begin
                we = 1'b1; wa = pos_reg[AW-1:0];
                if (is_max ? (cv > s_reg) : (cv < s_reg))
                begin
                    wd = cv;
                    if (pos_reg == '0)
                    begin
                        if (is_max) ltop_next = cv; else utop_next = cv;
                    end
                    pos_next = ci;
                    state_next = rmth_pkg::ST_DOWN_R;
                end
                else
                begin
                    wd = s_reg;
                    if (pos_reg == '0)
                    begin
                        if (is_max) ltop_next = s_reg; else utop_next = s_reg;
                    end
                    state_next = rmth_pkg::ST_LAST_C;
                end
            end
            // Pop helper: read last entry of the popped heap.
            rmth_pkg::ST_LAST_R:
            begin
                rda = hc_reg[AW-1:0];
                state_next = rmth_pkg::ST_LAST_C;
                phase_next = rmth_pkg::PH_LAST;
            end
            // Operation done: choose what follows.
            rmth_pkg::ST_LAST_C:
            begin
                if (phase_reg == rmth_pkg::PH_LAST)
                begin
                    // Last entry read: replace top with it, push old top.
                    s_next = ra_reg;
                    op_next = (hc_reg == '0) ? rmth_pkg::OP_NONE : rmth_pkg::OP_REPLACE;
                    phase_next = rmth_pkg::PH_REBAL;
                    state_next = rmth_pkg::ST_NEXT;
                end
                else if (op2_reg != rmth_pkg::OP_NONE)
                begin
                    op_next = op2_reg; side_next = side2_reg; s_next = mv_reg;
                    op2_next = rmth_pkg::OP_NONE;
                    state_next = rmth_pkg::ST_NEXT;
                end
                else if (phase_reg == rmth_pkg::PH_INSERT && ucnt_reg > lcnt_reg)
                begin
                    // Pop upper top, push it to lower.
                    mv_next = utop_reg;
                    ucnt_next = ucnt_reg - CW'(1);
                    hc_next = ucnt_reg - CW'(1);
                    side_next = rmth_pkg::SIDE_UPPER;
                    op2_next = rmth_pkg::OP_PUSH;
                    side2_next = rmth_pkg::SIDE_LOWER;
                    state_next = rmth_pkg::ST_LAST_R;
                end
                else if (phase_reg == rmth_pkg::PH_INSERT && lcnt_reg > ucnt_reg + CW'(1))
                begin
                    mv_next = ltop_reg;
                    lcnt_next = lcnt_reg - CW'(1);
                    hc_next = lcnt_reg - CW'(1);
                    side_next = rmth_pkg::SIDE_LOWER;
                    op2_next = rmth_pkg::OP_PUSH;
                    side2_next = rmth_pkg::SIDE_UPPER;
                    state_next = rmth_pkg::ST_LAST_R;
                end
                else
                begin
                    state_next = rmth_pkg::ST_OUT;
                end
            end
            // Form the result beat.
            rmth_pkg::ST_OUT:
            begin
                ovl_next = ov_reg;
                if (lcnt_reg == '0)
                begin
                    tm_next = '0;
                end
                else if (lcnt_reg[0] == ucnt_reg[0])
                begin
                    tm_next = {ltop_reg[VW-1], ltop_reg} + {utop_reg[VW-1], utop_reg};
                end
                else
                begin
                    tm_next = {ltop_reg, 1'b0};
                end
                state_next = rmth_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rmth_pkg::ST_IDLE;
            end
        endcase
    end

    logic out_load;
    assign out_load = (state_reg == rmth_pkg::ST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmth_pkg::ST_IDLE;
            lcnt_reg  <= '0;
            ucnt_reg  <= '0;
            out_valid <= 1'b0;
            op_reg    <= rmth_pkg::OP_NONE;
            op2_reg   <= rmth_pkg::OP_NONE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            op2_reg   <= op2_next;
            lcnt_reg  <= lcnt_next;
            ucnt_reg  <= ucnt_next;
            phase_reg <= phase_next;
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ltop_reg <= ltop_next; utop_reg <= utop_next;
        mv_reg <= mv_next;
        side2_reg <= side2_next; pos_reg <= pos_next; hc_reg <= hc_next;
        ov_reg <= ov_next; ovl_reg <= ovl_next; tm_reg <= tm_next;
        s_reg    <= s_next;
        side_reg <= side_next;
    end

    assign twice_median = tm_reg;
    assign overflow     = ovl_reg;

    // Checks on the sequencer.
    a_bal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmth_pkg::ST_OUT) |->
            (lcnt_reg == ucnt_reg || lcnt_reg == ucnt_reg + CW'(1)))
        else $error("heaps out of balance at result");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (lcnt_reg <= CAP) && (ucnt_reg <= CAP))
        else $error("heap count beyond capacity");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == rmth_pkg::ST_IDLE))
        else $error("result beat while a sample is in work");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(tm_reg) && $stable(ovl_reg)))
        else $error("stalled result beat changed");
endmodule
`default_nettype wire

// ----- tb/running_median_two_heaps_tb.sv -----
// Self-checking testbench for the two-heap running median block.
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps_tb;

    localparam int HALF_CAP   = 512;
    localparam int VAL_W      = 32;
    localparam int CYCLE_CAP  = 1000000;
    localparam int ITEM_GOAL  = 2000;

    // Expected result of one sample.
    typedef struct {
        logic signed [VAL_W:0] twice_med;
        logic                  dropped;
    } median_beat_t;

    // Median predictor and store of expected results.
    class median_board_t;
        longint       lo_heap[HALF_CAP];
        longint       hi_heap[HALF_CAP];
        int           lo_cnt;
        int           hi_cnt;
        median_beat_t pending[$];
        int           errors;
        int           checked;
        int           drops;

        function bit ahead(bit is_max, longint a, longint b);
            return is_max ? (a > b) : (a < b);
        endfunction

        function longint rd(bit side, int i);
            return (side == rmth_pkg::SIDE_UPPER) ? hi_heap[i] : lo_heap[i];
        endfunction

        function void wr(bit side, int i, longint v);
            if (side == rmth_pkg::SIDE_UPPER)
                hi_heap[i] = v;
            else
                lo_heap[i] = v;
        endfunction

        function void push(bit side, longint v);
            int i;
            int p;
            bit is_max;
            is_max = (side == rmth_pkg::SIDE_LOWER);
            i = (side == rmth_pkg::SIDE_UPPER) ? hi_cnt : lo_cnt;
            if (i >= HALF_CAP)
                return;
            if (side == rmth_pkg::SIDE_UPPER)
                hi_cnt++;
            else
                lo_cnt++;
            // sift up
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!ahead(is_max, v, rd(side, p)))
                    break;
                wr(side, i, rd(side, p));
                i = p;
            end
            wr(side, i, v);
        endfunction

        function void replace_top(bit side, int cnt, longint v);
            int i;
            int l;
            int c;
            bit is_max;
            is_max = (side == rmth_pkg::SIDE_LOWER);
            i = 0;
            if (cnt == 0)
                return;
            // sift down
            forever begin
                l = 2 * i + 1;
                if (l >= cnt)
                    break;
                c = l;
                if (l + 1 < cnt && ahead(is_max, rd(side, l + 1), rd(side, l)))
                    c = l + 1;
                if (!ahead(is_max, rd(side, c), v))
                    break;
                wr(side, i, rd(side, c));
                i = c;
            end
            wr(side, i, v);
        endfunction

        function longint pop(bit side);
            longint top;
            int cnt;
            cnt = (side == rmth_pkg::SIDE_UPPER) ? hi_cnt : lo_cnt;
            if (cnt == 0)
                return 0;
            top = rd(side, 0);
            cnt--;
            if (side == rmth_pkg::SIDE_UPPER)
                hi_cnt = cnt;
            else
                lo_cnt = cnt;
            if (cnt > 0)
                replace_top(side, cnt, rd(side, cnt));
            return top;
        endfunction

        // Note an accepted sample and queue its expected result.
        function void note_sample(logic signed [31:0] smp, logic fresh);
            longint s;
            longint sum;
            median_beat_t e;
            s = longint'(smp);
            e.dropped = 1'b0;
            if (fresh) begin
                lo_cnt = 0;
                hi_cnt = 0;
            end
            if (lo_cnt + hi_cnt >= 2 * HALF_CAP) begin
                e.dropped = 1'b1;
                drops++;
            end else begin
                if (lo_cnt > 0 && s > lo_heap[0])
                    push(rmth_pkg::SIDE_UPPER, s);
                else if (lo_cnt >= HALF_CAP) begin
                    push(rmth_pkg::SIDE_UPPER, lo_heap[0]);
                    replace_top(rmth_pkg::SIDE_LOWER, lo_cnt, s);
                end else
                    push(rmth_pkg::SIDE_LOWER, s);
                // rebalance
                if (hi_cnt > lo_cnt)
                    push(rmth_pkg::SIDE_LOWER, pop(rmth_pkg::SIDE_UPPER));
                else if (lo_cnt > hi_cnt + 1)
                    push(rmth_pkg::SIDE_UPPER, pop(rmth_pkg::SIDE_LOWER));
            end
            if (lo_cnt == 0)
                sum = 0;
            else if (((lo_cnt + hi_cnt) % 2) == 0)
                sum = lo_heap[0] + hi_heap[0];
            else
                sum = lo_heap[0] + lo_heap[0];
            e.twice_med = sum[VAL_W:0];
            pending.push_back(e);
        endfunction

        // Compare a result beat with the oldest expectation.
        function void check_result(logic signed [VAL_W:0] tm, logic ov);
            median_beat_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result twice_median=%0d overflow=%0b",
                         $time, tm, ov);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (tm !== e.twice_med) begin
                $display("%0t: twice_median expected %0d actual %0d",
                         $time, e.twice_med, tm);
                errors++;
            end
            if (ov !== e.dropped) begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.dropped, ov);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [31:0]      sample;
    logic                    start_new;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [VAL_W:0]   twice_median;
    logic                    overflow;

    median_board_t board;
    bit          calm;
    int          cycles;
    int          n_items;
    int          n_seqs;

    running_median_two_heaps #(
        .HALF_CAPACITY(HALF_CAP),
        .VALUE_WIDTH(VAL_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .start_new(start_new),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .twice_median(twice_median),
        .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound the run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Take result beats, stalling at random outside the calm stretch.
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_result(twice_median, overflow);
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 11);
        end
    end

    // Drive one sample beat and hold it until accepted, then maybe idle.
    task automatic send_beat(logic signed [31:0] s, logic fresh);
        in_valid  <= 1'b1;
        sample    <= s;
        start_new <= fresh;
        do
            @(posedge clk);
        while (in_stall);
        board.note_sample(s, fresh);
        n_items++;
        if (fresh)
            n_seqs++;
        if (!calm && $urandom_range(99) < 11) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $signed($urandom_range(16)) - 8;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int len;
        bit long_done;
        board     = new();
        cycles    = 0;
        calm      = 1'b0;
        long_done = 1'b0;
        n_items   = 0;
        n_seqs    = 0;
        in_valid  = 1'b0;
        sample    = '0;
        start_new = 1'b0;
        rst_n     = 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no start flag yet, extremes, ties, largest sums, restarts.
        send_beat(32'sd5, 1'b0);
        send_beat(32'sh7fffffff, 1'b0);
        send_beat(32'sh7fffffff, 1'b0);
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sd0, 1'b0);
        send_beat(-32'sd1, 1'b0);
        send_beat(32'sh80000000, 1'b1);
        send_beat(32'sh80000000, 1'b0);
        send_beat(32'sh7fffffff, 1'b1);
        send_beat(32'sh7fffffff, 1'b0);
        send_beat(32'sd3, 1'b1);
        send_beat(32'sd3, 1'b0);
        send_beat(32'sd3, 1'b0);
        send_beat(32'sd1, 1'b0);
        send_beat(32'sd9, 1'b0);
        send_beat(32'sh55555555, 1'b1);
        send_beat(32'shaaaaaaaa, 1'b0);

        // Random sequences; one long run fills both heaps and overflows.
        while (n_items < ITEM_GOAL) begin
            if (!long_done && n_items > 400) begin
                long_done = 1'b1;
                calm = 1'b1;
                len = 2 * HALF_CAP + 12;
            end else begin
                calm = 1'b0;
                len = $urandom_range(1, 40);
            end
            for (int k = 0; k < len; k++) begin
                // mostly whole sequences, with the odd restart in the middle
                send_beat(pick_value(), (k == 0) || (!calm && $urandom_range(99) < 2));
                // near full heaps, favor the lower half to refill it
                if (calm && k == 2 * HALF_CAP - 3)
                    send_beat(32'sh80000000, 1'b0);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain and let any trailing work settle.
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);

        $display("Sent %0d samples in %0d sequences; %0d results checked, %0d dropped.",
                 n_items, n_seqs, board.checked, board.drops);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
sv/rmth_pkg.sv
sv/running_median_two_heaps.sv
tb/running_median_two_heaps_tb.sv
